// File: src/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and constants for the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 32;   // declared length, two's complement
  localparam int unsigned MAXLEN_W = 31;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned HCNT_W   = 3;
  localparam int unsigned CIDX_W   = 2;

  // header bytes carrying the length, type byte follows
  localparam logic [HCNT_W-1:0] LEN_BYTES = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LARGE = 2'd3;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CIDX_W-1:0] REG_END_MARKER   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_MAX_PAYLOAD  = 2'd2;

  // register reset values
  localparam logic [BYTE_W-1:0]   START_MARKER_RST = 8'h02;
  localparam logic [BYTE_W-1:0]   END_MARKER_RST   = 8'h03;
  localparam logic [MAXLEN_W-1:0] MAX_PAYLOAD_RST  = 31'd1024;

  typedef struct packed {
    logic [BYTE_W-1:0]   start_marker;
    logic [BYTE_W-1:0]   end_marker;
    logic [MAXLEN_W-1:0] max_payload;
  } cfg_t;

endpackage

// File: src/lpfr_cfg.sv
// ----------------------------------------------------------------------------
// lpfr_cfg
// Configuration register bank; decodes index and captures write data.
// ----------------------------------------------------------------------------
module lpfr_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lpfr_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [lpfr_pkg::MAXLEN_W-1:0]  cfg_data,
  output lpfr_pkg::cfg_t                 cfg_o
);

  lpfr_pkg::cfg_t cfg_r;
  lpfr_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        lpfr_pkg::REG_START_MARKER: cfg_nxt.start_marker = cfg_data[lpfr_pkg::BYTE_W-1:0];
        lpfr_pkg::REG_END_MARKER:   cfg_nxt.end_marker   = cfg_data[lpfr_pkg::BYTE_W-1:0];
        lpfr_pkg::REG_MAX_PAYLOAD:  cfg_nxt.max_payload  = cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= lpfr_pkg::START_MARKER_RST;
      cfg_r.end_marker   <= lpfr_pkg::END_MARKER_RST;
      cfg_r.max_payload  <= lpfr_pkg::MAX_PAYLOAD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/length_prefixed_frame_receiver.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Hunts for a start marker, parses a length/type header, streams payload,
// and checks the end marker.
// ----------------------------------------------------------------------------
// One received byte per beat, one byte per cycle sustained. Each byte is
// processed in the cycle it is accepted and its result (if any) lands in the
// output register; the input takes a byte whenever that register is empty or
// is being drained in the same cycle, so in_tready follows out_tready.
// A byte yields at most one result beat: a payload byte, frame good, bad end
// marker, or length too large. Non-positive lengths and hunt/skip bytes
// produce nothing. Registers should be written only while the block is idle.
module length_prefixed_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [7:0] data, [15:8] frame_type,
                                   // [46:16] frame_length, [47] zero
  output logic [1:0]  out_tuser,   // [1:0] kind
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_END     = 3'd3,
    PH_SKIP    = 3'd4
  } phase_t;

  lpfr_pkg::cfg_t cfg;

  lpfr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  phase_t                              phase_r,   phase_nxt;
  logic [lpfr_pkg::HCNT_W-1:0]         hcnt_r,    hcnt_nxt;
  logic [lpfr_pkg::LEN_W-1:0]          len_r,     len_nxt;
  logic [lpfr_pkg::MAXLEN_W-1:0]       pcnt_r,    pcnt_nxt;
  logic [lpfr_pkg::BYTE_W-1:0]         type_r,    type_nxt;

  logic                                out_valid_r;
  logic [lpfr_pkg::KIND_W-1:0]         out_kind_r, res_kind;
  logic [lpfr_pkg::BYTE_W-1:0]         out_data_r, res_data;
  logic [lpfr_pkg::BYTE_W-1:0]         out_type_r;
  logic [lpfr_pkg::MAXLEN_W-1:0]       out_len_r;
  logic                                res_valid;

  logic                                in_fire;
  logic [lpfr_pkg::BYTE_W-1:0]         rx_byte;
  logic [lpfr_pkg::MAXLEN_W-1:0]       pcnt_inc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign rx_byte   = in_tdata;
  assign pcnt_inc  = pcnt_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    len_nxt   = len_r;
    pcnt_nxt  = pcnt_r;
    type_nxt  = type_r;
    res_valid = 1'b0;
    res_kind  = lpfr_pkg::KIND_DATA;
    res_data  = '0;
    case (phase_r)
      PH_HEADER: begin
        if (hcnt_r < lpfr_pkg::LEN_BYTES) begin
          len_nxt  = {len_r[lpfr_pkg::LEN_W-lpfr_pkg::BYTE_W-1:0], rx_byte};
          hcnt_nxt = hcnt_r + 1'b1;
        end else begin
          type_nxt = rx_byte;
          hcnt_nxt = '0;
          pcnt_nxt = '0;
          if (len_r[lpfr_pkg::LEN_W-1] || len_r == '0) begin
            phase_nxt = PH_HUNT;
          end else if (len_r[lpfr_pkg::MAXLEN_W-1:0] > cfg.max_payload) begin
            phase_nxt = PH_HUNT;
            res_valid = 1'b1;
            res_kind  = lpfr_pkg::KIND_LARGE;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pcnt_nxt  = pcnt_inc;
        // sign bit is clear here, low bits hold the whole length
        if (pcnt_inc >= len_r[lpfr_pkg::MAXLEN_W-1:0]) begin
          phase_nxt = PH_END;
        end
        res_valid = 1'b1;
        res_kind  = lpfr_pkg::KIND_DATA;
        res_data  = rx_byte;
      end
      PH_END: begin
        res_valid = 1'b1;
        if (rx_byte == cfg.end_marker) begin
          phase_nxt = PH_HUNT;
          res_kind  = lpfr_pkg::KIND_GOOD;
        end else begin
          phase_nxt = PH_SKIP;
          res_kind  = lpfr_pkg::KIND_BAD;
        end
      end
      PH_SKIP: begin
        if (rx_byte == cfg.end_marker) begin
          phase_nxt = PH_HUNT;
        end
      end
      default: begin  // hunting, and any stray code
        if (rx_byte == cfg.start_marker) begin
          phase_nxt = PH_HEADER;
          hcnt_nxt  = '0;
          len_nxt   = '0;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      hcnt_r      <= '0;
      len_r       <= '0;
      pcnt_r      <= '0;
      type_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        hcnt_r  <= hcnt_nxt;
        len_r   <= len_nxt;
        pcnt_r  <= pcnt_nxt;
        type_r  <= type_nxt;
      end
      if (in_fire) begin
        out_valid_r <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_fire && res_valid) begin
      out_kind_r <= res_kind;
      out_data_r <= res_data;
      out_type_r <= type_nxt;
      out_len_r  <= len_nxt[lpfr_pkg::MAXLEN_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_len_r, out_type_r, out_data_r};

  // length in payload phase is positive and not yet consumed
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (!len_r[31] && ({1'b0, pcnt_r} < len_r)))
    else $error("payload phase with bad length or count");

  a_hcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= lpfr_pkg::LEN_BYTES)
    else $error("header count out of range");

  // a result beat only leaves the payload or end phases, or on a large length
  a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_valid && phase_r == PH_HEADER) |=>
      (phase_r == PH_HUNT && out_kind_r == lpfr_pkg::KIND_LARGE))
    else $error("header byte produced wrong result");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed frame receiver. A queue of bytes
// feeds a stream driver; each accepted byte runs through a deframing predictor
// whose result beats are compared, field by field, with the output stream.
// Covers directed frames, several marker/limit settings and random traffic
// with bursty stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [lpfr_pkg::CIDX_W-1:0] REG_UNUSED = 2'd3;   // no register behind it
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_BYTES   = 125;

  typedef enum logic [2:0] {
    RX_HUNT, RX_HEADER, RX_PAYLOAD, RX_END, RX_SKIP
  } rx_phase_t;

  typedef struct packed {
    logic [lpfr_pkg::KIND_W-1:0]   kind;
    logic [lpfr_pkg::BYTE_W-1:0]   data;
    logic [lpfr_pkg::BYTE_W-1:0]   ftype;
    logic [lpfr_pkg::MAXLEN_W-1:0] flen;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  length_prefixed_frame_receiver DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor registers and state
  logic [lpfr_pkg::BYTE_W-1:0]   start_mark = lpfr_pkg::START_MARKER_RST;
  logic [lpfr_pkg::BYTE_W-1:0]   end_mark   = lpfr_pkg::END_MARKER_RST;
  logic [lpfr_pkg::MAXLEN_W-1:0] max_len    = lpfr_pkg::MAX_PAYLOAD_RST;
  rx_phase_t                     rx_phase   = RX_HUNT;
  logic [lpfr_pkg::HCNT_W-1:0]   hdr_cnt    = '0;
  logic [lpfr_pkg::LEN_W-1:0]    len_reg    = '0;
  logic [lpfr_pkg::MAXLEN_W-1:0] pay_cnt    = '0;
  logic [lpfr_pkg::BYTE_W-1:0]   type_reg   = '0;

  logic [7:0]  rx_bytes[$];
  frame_beat_t beats_due[$];

  bit idle_on     = 1'b1;
  bit hold_armed  = 1'b0;
  int errors      = 0;
  int cycles      = 0;
  int phase_count = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  task automatic expect_beat(input logic [lpfr_pkg::KIND_W-1:0] kind,
                             input logic [7:0] data);
    frame_beat_t b;
    b.kind  = kind;
    b.data  = data;
    b.ftype = type_reg;
    b.flen  = len_reg[lpfr_pkg::MAXLEN_W-1:0];
    beats_due.push_back(b);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    case (rx_phase)
      RX_HEADER: begin
        if (hdr_cnt < lpfr_pkg::LEN_BYTES) begin
          len_reg = {len_reg[lpfr_pkg::LEN_W-9:0], b};
          hdr_cnt = hdr_cnt + 1'b1;
        end else begin
          type_reg = b;
          hdr_cnt  = '0;
          pay_cnt  = '0;
          if (len_reg[lpfr_pkg::LEN_W-1] || len_reg == '0) begin
            rx_phase = RX_HUNT;
          end else if (len_reg > {1'b0, max_len}) begin
            rx_phase = RX_HUNT;
            expect_beat(lpfr_pkg::KIND_LARGE, '0);
          end else begin
            rx_phase = RX_PAYLOAD;
          end
        end
      end
      RX_PAYLOAD: begin
        pay_cnt = pay_cnt + 1'b1;
        if ({1'b0, pay_cnt} >= len_reg) rx_phase = RX_END;
        expect_beat(lpfr_pkg::KIND_DATA, b);
      end
      RX_END: begin
        if (b == end_mark) begin
          rx_phase = RX_HUNT;
          expect_beat(lpfr_pkg::KIND_GOOD, '0);
        end else begin
          rx_phase = RX_SKIP;
          expect_beat(lpfr_pkg::KIND_BAD, '0);
        end
      end
      RX_SKIP: begin
        if (b == end_mark) rx_phase = RX_HUNT;
      end
      default: begin
        if (b == start_mark) begin
          rx_phase = RX_HEADER;
          hdr_cnt  = '0;
          len_reg  = '0;
        end else begin
          rx_phase = RX_HUNT;
        end
      end
    endcase
  endtask

  // ------------------------------------------------------------------- driver
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
        void'(rx_bytes.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // beat still pending, hold it
      end else if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 19) - 1;
        in_tvalid <= 1'b0;
      end else if (rx_bytes.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= rx_bytes[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------ monitor
  int  recv_gap  = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  task automatic field_check(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic check_beat();
    frame_beat_t want;
    if (beats_due.size() == 0) begin
      $display("%0t: result beat with nothing expected, expected none, actual kind %0d tdata %h",
               $time, out_tuser, out_tdata);
      errors++;
    end else begin
      want = beats_due.pop_front();
      field_check("kind",         want.kind,  out_tuser);
      field_check("data",         want.data,  out_tdata[7:0]);
      field_check("frame_type",   want.ftype, out_tdata[15:8]);
      field_check("frame_length", want.flen,  out_tdata[46:16]);
      field_check("pad bit",      '0,         out_tdata[47]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_beat();
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic put(input logic [7:0] b);
    rx_bytes.push_back(b);
    phase_count++;
  endtask

  function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom);
    while (b == avoid) b = 8'($urandom);
    return b;
  endfunction

  task automatic put_header(input logic [31:0] len, input logic [7:0] ftype);
    put(start_mark);
    put(len[31:24]);
    put(len[23:16]);
    put(len[15:8]);
    put(len[7:0]);
    put(ftype);
  endtask

  task automatic put_payload(input int n);
    for (int i = 0; i < n; i++) put(8'($urandom));
  endtask

  task automatic write_reg(input logic [lpfr_pkg::CIDX_W-1:0] idx, input logic [30:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lpfr_pkg::REG_START_MARKER: start_mark = val[7:0];
      lpfr_pkg::REG_END_MARKER:   end_mark   = val[7:0];
      lpfr_pkg::REG_MAX_PAYLOAD:  max_len    = val;
      default: ;
    endcase
  endtask

  // upper data bits are don't-care for the marker registers
  task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
    write_reg(lpfr_pkg::REG_START_MARKER, {23'($urandom), s});
    write_reg(lpfr_pkg::REG_END_MARKER,   {23'($urandom), e});
  endtask

  task automatic wait_drained();
    while (rx_bytes.size() != 0 || beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_random_frame();
    int          sel;
    int          lim;
    logic [31:0] len;
    sel = $urandom_range(0, 99);
    lim = (max_len < 12) ? int'(max_len) : 12;
    if (sel >= 72 && sel < 82 || (sel < 72 && lim == 0)) begin
      // oversized, falls back to a negative length if nothing can exceed the limit
      if (max_len == 31'h7FFFFFFF) len = {1'b1, 31'($urandom)};
      else len = $urandom_range({1'b0, max_len} + 1, 32'h7FFFFFFF);
      put_header(len, 8'($urandom));
      repeat ($urandom_range(0, 3)) put(byte_other_than(start_mark));
    end else if (sel < 72) begin
      if ($urandom_range(0, 19) == 0 && max_len > 12)
        len = $urandom_range(1, (max_len < 64) ? int'(max_len) : 64);
      else
        len = $urandom_range(1, lim);
      put_header(len, 8'($urandom));
      put_payload(len);
      if (sel < 60) begin
        put(end_mark);
      end else begin
        put(byte_other_than(end_mark));
        repeat ($urandom_range(0, 3)) put(byte_other_than(end_mark));
        put(end_mark);
      end
    end else if (sel < 90) begin
      if ($urandom_range(0, 3) == 0) len = '0;
      else len = {1'b1, 31'($urandom)};
      put_header(len, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) put(byte_other_than(start_mark));
    end
  endtask

  task automatic run_phase(input int budget);
    phase_count = 0;
    while (phase_count < budget) put_random_frame();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: good frame at byte extremes
    put_header(32'd1, 8'hFF);
    put(8'h00);
    put(end_mark);
    put_header(32'd1025, 8'h5A);          // one over the limit
    put_header(32'd0, 8'h11);             // zero length, silent
    put_header(32'hFFFFFFFF, 8'h22);      // negative length, silent
    // bad end marker; a start marker while skipping is ignored
    put_header(32'd2, 8'h33);
    put(8'hAA);
    put(end_mark);
    put(8'h00);
    put(start_mark);
    put(end_mark);
    wait_drained();

    // limit zero: every positive length is too large
    write_reg(REG_UNUSED, 31'($urandom));
    set_markers(8'h00, 8'hFF);
    write_reg(lpfr_pkg::REG_MAX_PAYLOAD, 31'd0);
    run_phase(100);
    wait_drained();

    // widest limit; receiver holds off while the sender keeps offering
    set_markers(8'hFF, 8'h00);
    write_reg(lpfr_pkg::REG_MAX_PAYLOAD, 31'h7FFFFFFF);
    run_phase(PHASE_BYTES);
    hold_armed = 1'b1;
    wait_drained();

    // settings change while a header is half collected
    put(start_mark);
    put(8'h00);
    put(8'h00);
    wait_drained();
    write_reg(lpfr_pkg::REG_MAX_PAYLOAD, 31'd6);
    write_reg(lpfr_pkg::REG_END_MARKER, {23'($urandom), 8'h5A});
    put(8'h00);
    put(8'h06);                           // length equal to the new limit
    put(8'h77);
    put_payload(6);
    put(end_mark);
    put_header(32'd7, 8'h78);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      set_markers(8'($urandom), 8'($urandom));
      case ($urandom_range(0, 2))
        0:       write_reg(lpfr_pkg::REG_MAX_PAYLOAD, 31'($urandom_range(1, 40)));
        1:       write_reg(lpfr_pkg::REG_MAX_PAYLOAD, 31'($urandom_range(1, 1024)));
        default: write_reg(lpfr_pkg::REG_MAX_PAYLOAD, 31'($urandom));
      endcase
      if (ph == 4) idle_on = 1'b0;
      run_phase(PHASE_BYTES);
      wait_drained();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
